@@ hw/rtl/firrt_pkg.sv @@
// ============================================================================
// firrt_pkg: shared definitions for the real-tap FIR filter
// Sizes, register indexes, request codes and the types passed between the
// control logic, the delay cells and the multiply-accumulate unit.
// ============================================================================
package firrt_pkg;

    // Array and field sizes.
    localparam int MAX_TAPS     = 128;
    localparam int SAMPLE_WIDTH = 16;
    localparam int TAP_W        = 16;
    localparam int TAP_FRAC     = 15;
    localparam int NUM_TAPS_W   = 8;
    localparam int TAP_INDEX_W  = 7;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 8;

    // Derived widths.
    localparam int ADDR_W = $clog2(MAX_TAPS);
    localparam int CNT_W  = $clog2(MAX_TAPS + 1);
    localparam int PROD_W = SAMPLE_WIDTH + TAP_W;
    localparam int ACC_W  = PROD_W + ADDR_W;
    localparam int RND_W  = ACC_W - TAP_FRAC;

    // Configuration register indexes.
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t REG_NUM_TAPS     = cfg_idx_t'(0);
    localparam cfg_idx_t REG_COMPLEX_MODE = cfg_idx_t'(1);

    // Request type codes.
    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_LOAD   = 1'b1;

    // One complex sample as held in a delay cell.
    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] re;
        logic signed [SAMPLE_WIDTH-1:0] im;
    } cpx_t;

    // Delay chain control: shift a new sample in, or rotate toward cell zero.
    typedef struct packed {
        logic shift;
        logic rotate;
    } cell_ctl_t;

    // Accumulator control: clear for a new sample, take one product step.
    typedef struct packed {
        logic clear;
        logic step;
    } mac_ctl_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_FIN
    } state_t;

endpackage

@@ hw/rtl/firrt_cell.sv @@
// ============================================================================
// firrt_cell: one delay-line cell
// Holds one complex sample. Takes its left neighbor's sample on a shift and
// its right neighbor's sample on a rotation.
// ============================================================================
module firrt_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  firrt_pkg::cell_ctl_t ctl,
    input  firrt_pkg::cpx_t     prev_data,
    input  firrt_pkg::cpx_t     next_data,
    output firrt_pkg::cpx_t     data
);
    import firrt_pkg::*;

    cpx_t data_reg;
    cpx_t data_next;

    // Select the neighbor to take from.
    always_comb
    begin
        data_next = data_reg;
        if (ctl.shift)
        begin
            data_next = prev_data;
        end
        else if (ctl.rotate)
        begin
            data_next = next_data;
        end
    end

    // The delay line starts out at zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_reg <= '0;
        end
        else
        begin
            data_reg <= data_next;
        end
    end

    assign data = data_reg;

endmodule

@@ hw/rtl/firrt_tap_store.sv @@
// ============================================================================
// firrt_tap_store: tap coefficient memory
// One write port and one registered read port. Entries never written since
// reset read as zero through a row of valid bits.
// ============================================================================
module firrt_tap_store (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 wr_en,
    input  logic [firrt_pkg::ADDR_W-1:0]         wr_addr,
    input  logic signed [firrt_pkg::TAP_W-1:0]   wr_data,
    input  logic                                 rd_en,
    input  logic [firrt_pkg::ADDR_W-1:0]         rd_addr,
    output logic signed [firrt_pkg::TAP_W-1:0]   rd_data
);
    import firrt_pkg::*;

    logic signed [TAP_W-1:0] mem [MAX_TAPS];
    logic [MAX_TAPS-1:0]     valid_reg;
    logic signed [TAP_W-1:0] rd_data_reg;

    // Valid bits mark entries that hold a loaded tap.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    // Memory write.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read; an entry not yet loaded reads as zero.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= valid_reg[rd_addr] ? mem[rd_addr] : '0;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hw/rtl/firrt_mac.sv @@
// ============================================================================
// firrt_mac: complex-by-real multiply-accumulate
// Multiplies the sample leaving delay cell zero by the tap read from the
// store, accumulates both lanes, and rounds and saturates the sums.
// ============================================================================
module firrt_mac (
    input  logic                                clk,
    input  logic                                rst_n,
    input  firrt_pkg::mac_ctl_t                 ctl,
    input  logic signed [firrt_pkg::TAP_W-1:0]  tap,
    input  firrt_pkg::cpx_t                     x,
    output firrt_pkg::cpx_t                     y
);
    import firrt_pkg::*;

    localparam logic signed [ACC_W-1:0] RND_BIAS = ACC_W'(2 ** (TAP_FRAC - 1));
    localparam logic signed [RND_W-1:0] SAT_HI   = RND_W'(2 ** (SAMPLE_WIDTH - 1) - 1);
    localparam logic signed [RND_W-1:0] SAT_LO   = -SAT_HI - RND_W'(1);

    cpx_t                     x_reg;
    logic                     en_reg;
    logic signed [ACC_W-1:0]  acc_re_reg;
    logic signed [ACC_W-1:0]  acc_im_reg;
    logic signed [ACC_W-1:0]  acc_re_next;
    logic signed [ACC_W-1:0]  acc_im_next;
    logic signed [PROD_W-1:0] prod_re;
    logic signed [PROD_W-1:0] prod_im;

    // Round to nearest (ties upward) and clamp to the sample range.
    function automatic logic signed [SAMPLE_WIDTH-1:0] round_sat(
        input logic signed [ACC_W-1:0] a
    );
        logic signed [ACC_W-1:0]        biased;
        logic signed [RND_W-1:0]        q;
        logic signed [SAMPLE_WIDTH-1:0] r;
        biased = a + RND_BIAS;
        q      = RND_W'(biased >>> TAP_FRAC);
        if (q > SAT_HI)
        begin
            r = SAMPLE_WIDTH'(SAT_HI);
        end
        else if (q < SAT_LO)
        begin
            r = SAMPLE_WIDTH'(SAT_LO);
        end
        else
        begin
            r = SAMPLE_WIDTH'(q);
        end
        return r;
    endfunction

    // Sample register lines up with the registered tap read.
    always_ff @(posedge clk)
    begin
        x_reg <= x;
    end

    // Products of the current tap with both lanes.
    assign prod_re = PROD_W'($signed(tap)) * PROD_W'($signed(x_reg.re));
    assign prod_im = PROD_W'($signed(tap)) * PROD_W'($signed(x_reg.im));

    // Accumulator update.
    always_comb
    begin
        acc_re_next = acc_re_reg;
        acc_im_next = acc_im_reg;
        if (ctl.clear)
        begin
            acc_re_next = '0;
            acc_im_next = '0;
        end
        else if (en_reg)
        begin
            acc_re_next = acc_re_reg + ACC_W'(prod_re);
            acc_im_next = acc_im_reg + ACC_W'(prod_im);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_reg     <= 1'b0;
            acc_re_reg <= '0;
            acc_im_reg <= '0;
        end
        else
        begin
            en_reg     <= ctl.step;
            acc_re_reg <= acc_re_next;
            acc_im_reg <= acc_im_next;
        end
    end

    assign y.re = round_sat(acc_re_reg);
    assign y.im = round_sat(acc_im_reg);

endmodule

@@ hw/rtl/fir_filter_real_taps.sv @@
// ============================================================================
// fir_filter_real_taps: FIR filter with real taps over real or complex samples
// Delay line of shifting cells, a tap store and one shared complex MAC.
// ============================================================================
// A tap load is written to the tap store on the accepting edge. In a sample
// transaction the sample is shifted into the delay chain on the accepting
// edge, then the chain rotates once per cycle in ST_RUN, MAX_TAPS rotations
// in all, so every cell passes cell zero and the single MAC pairs it with
// its tap, then ST_DRAIN drains the MAC pipeline and ST_FIN rounds and
// saturates into the output register once that register is empty or being
// taken. The rotation count is fixed whatever num_taps is set to. A new
// transaction is accepted while a finished result still waits in the output register. Taps read as zero until loaded.
module fir_filter_real_taps (
    input  logic                                      clk,
    input  logic                                      rst_n,
    // Request channel
    input  logic                                      in_valid,
    output logic                                      in_stall,
    input  logic                                      req_type,
    input  logic [firrt_pkg::TAP_INDEX_W-1:0]         tap_index,
    input  logic signed [firrt_pkg::TAP_W-1:0]        tap_value,
    input  logic signed [firrt_pkg::SAMPLE_WIDTH-1:0] sample_re,
    input  logic signed [firrt_pkg::SAMPLE_WIDTH-1:0] sample_im,
    // Result channel
    output logic                                      out_valid,
    input  logic                                      out_stall,
    output logic signed [firrt_pkg::SAMPLE_WIDTH-1:0] out_re,
    output logic signed [firrt_pkg::SAMPLE_WIDTH-1:0] out_im,
    // Configuration write channel
    input  logic                                      cfg_valid,
    output logic                                      cfg_ready,
    input  logic [firrt_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  logic [firrt_pkg::CFG_DATA_W-1:0]          cfg_data
);
    import firrt_pkg::*;

    localparam int CMP_W = (NUM_TAPS_W > CNT_W) ? NUM_TAPS_W : CNT_W;
    localparam logic [ADDR_W-1:0] LAST_STEP = ADDR_W'(MAX_TAPS - 1);

    // Configuration registers
    logic [NUM_TAPS_W-1:0] num_taps_reg;
    logic                  complex_mode_reg;

    // Sequencer
    state_t              state_reg;
    state_t              state_next;
    logic [ADDR_W-1:0]   step_reg;
    logic [ADDR_W-1:0]   step_next;
    logic [CNT_W-1:0]    rem_reg;
    logic [CNT_W-1:0]    rem_next;
    logic [ADDR_W-1:0]   addr_reg;
    logic [ADDR_W-1:0]   addr_next;

    // Datapath control and data
    cell_ctl_t               cell_ctl;
    mac_ctl_t                mac_ctl;
    logic                    rd_en;
    logic                    out_load;
    logic                    in_accept;
    logic                    out_accept;
    logic                    tap_wr;
    logic                    tap_in_range;
    logic [CMP_W-1:0]        nt_ext;
    logic [CNT_W-1:0]        n_eff;
    logic signed [TAP_W-1:0] tap_rd;
    cpx_t                    new_sample;
    cpx_t                    cell_q [MAX_TAPS];
    cpx_t                    mac_y;

    // Output register
    logic                           out_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0] out_re_reg;
    logic signed [SAMPLE_WIDTH-1:0] out_im_reg;

    // Handshakes
    assign in_stall   = (state_reg != ST_IDLE);
    assign in_accept  = in_valid && !in_stall;
    assign out_accept = out_valid_reg && !out_stall;
    assign cfg_ready  = 1'b1;

    // Configuration writes; unknown indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_taps_reg     <= NUM_TAPS_W'(1);
            complex_mode_reg <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_NUM_TAPS:     num_taps_reg     <= cfg_data[NUM_TAPS_W-1:0];
                REG_COMPLEX_MODE: complex_mode_reg <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    // Taps in use, clamped to the store depth.
    assign nt_ext = CMP_W'(num_taps_reg);
    assign n_eff  = (nt_ext > CMP_W'(MAX_TAPS)) ? CNT_W'(MAX_TAPS) : CNT_W'(nt_ext);

    // Tap loads beyond the store are ignored.
    assign tap_in_range = (32'(tap_index) < 32'(MAX_TAPS));
    assign tap_wr       = in_accept && (req_type == REQ_LOAD) && tap_in_range;

    // In real mode the imaginary part enters the delay line as zero.
    assign new_sample.re = sample_re;
    assign new_sample.im = complex_mode_reg ? sample_im : '0;

    // Sequencer next state and datapath control.
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        rem_next   = rem_reg;
        addr_next  = addr_reg;
        cell_ctl   = '0;
        mac_ctl    = '0;
        rd_en      = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && (req_type == REQ_SAMPLE))
                begin
                    cell_ctl.shift = 1'b1;
                    mac_ctl.clear  = 1'b1;
                    rem_next       = n_eff;
                    addr_next      = ADDR_W'(n_eff - CNT_W'(1));
                    step_next      = '0;
                    state_next     = ST_RUN;
                end
            end
            ST_RUN:
            begin
                // Cell zero holds delay entry m at step m; its tap is n-1-m.
                cell_ctl.rotate = 1'b1;
                if (rem_reg != '0)
                begin
                    rd_en        = 1'b1;
                    mac_ctl.step = 1'b1;
                    rem_next     = rem_reg - CNT_W'(1);
                    addr_next    = addr_reg - ADDR_W'(1);
                end
                step_next = step_reg + ADDR_W'(1);
                if (step_reg == LAST_STEP)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            rem_reg   <= '0;
            addr_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            rem_reg   <= rem_next;
            addr_reg  <= addr_next;
        end
    end

    // Delay chain; on rotation cell zero wraps around to the last cell.
    for (genvar k = 0; k < MAX_TAPS; k++)
    begin : g_cell
        cpx_t prev_d;
        if (k == 0)
        begin : g_head
            assign prev_d = new_sample;
        end
        else
        begin : g_body
            assign prev_d = cell_q[k-1];
        end
        firrt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (cell_ctl),
            .prev_data (prev_d),
            .next_data (cell_q[(k + 1) % MAX_TAPS]),
            .data      (cell_q[k])
        );
    end

    // Tap store.
    firrt_tap_store u_tap_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (tap_wr),
        .wr_addr (ADDR_W'(tap_index)),
        .wr_data (tap_value),
        .rd_en   (rd_en),
        .rd_addr (addr_reg),
        .rd_data (tap_rd)
    );

    // Shared multiply-accumulate.
    firrt_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (mac_ctl),
        .tap   (tap_rd),
        .x     (cell_q[0]),
        .y     (mac_y)
    );

    // Output register; a load wins over a transaction that empties it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_accept)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_re_reg <= mac_y.re;
            out_im_reg <= complex_mode_reg ? mac_y.im : '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_re    = out_re_reg;
    assign out_im    = out_im_reg;

`ifndef NO_ASSERTIONS
    // A sample transaction starts the rotation at step zero.
    a_sample_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && (req_type == REQ_SAMPLE)) |=> (state_reg == ST_RUN) && (step_reg == '0))
        else $error("sample transaction did not start the rotation");

    // All taps in use have been read by the end of the rotation.
    a_taps_done: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_RUN) && (step_reg == LAST_STEP)) |=>
            (state_reg == ST_DRAIN) && (rem_reg == '0))
        else $error("rotation ended with taps left to read");

    // The idle sequencer has no tap reads pending.
    a_idle_no_reads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (rem_reg == '0))
        else $error("tap reads pending while idle");

    // A result appears only from the finishing step.
    a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_FIN))
        else $error("result appeared outside the finishing step");
`endif

endmodule

@@ test/fir_filter_real_taps_checker.sv @@
// ============================================================================
// fir_filter_real_taps_checker: result predictor and comparator
// Watches the request, result and configuration channels of the real-tap FIR
// filter. It keeps its own tap store, delay line and register copies, works
// out the filtered output for every accepted sample transaction and compares
// each accepted result with the oldest outstanding prediction.
// ============================================================================
module fir_filter_real_taps_checker (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      in_valid,
    input  logic                                      in_stall,
    input  logic                                      req_type,
    input  logic [firrt_pkg::TAP_INDEX_W-1:0]         tap_index,
    input  logic signed [firrt_pkg::TAP_W-1:0]        tap_value,
    input  logic signed [firrt_pkg::SAMPLE_WIDTH-1:0] sample_re,
    input  logic signed [firrt_pkg::SAMPLE_WIDTH-1:0] sample_im,
    input  logic                                      out_valid,
    input  logic                                      out_stall,
    input  logic signed [firrt_pkg::SAMPLE_WIDTH-1:0] out_re,
    input  logic signed [firrt_pkg::SAMPLE_WIDTH-1:0] out_im,
    input  logic                                      cfg_valid,
    input  logic                                      cfg_ready,
    input  logic [firrt_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  logic [firrt_pkg::CFG_DATA_W-1:0]          cfg_data,
    output int                                        mismatches,
    output int                                        outstanding
);
    import firrt_pkg::*;

    // Shadow copy of the filter state and registers.
    logic signed [TAP_W-1:0]        coef [MAX_TAPS];
    logic signed [SAMPLE_WIDTH-1:0] hist_re [MAX_TAPS];
    logic signed [SAMPLE_WIDTH-1:0] hist_im [MAX_TAPS];
    logic [NUM_TAPS_W-1:0]          taps_in_use;
    logic                           cplx_mode;

    // Predicted outputs waiting for their result transaction.
    cpx_t filtered_q[$];
    cpx_t want;
    int   errors;
    int   k;

    // Round to nearest with ties toward plus infinity, then clamp to the
    // signed sample range.
    function automatic logic signed [SAMPLE_WIDTH-1:0] round_clamp(input longint acc);
        longint q;
        longint hi_lim;
        longint lo_lim;
        hi_lim = (longint'(1) <<< (SAMPLE_WIDTH - 1)) - 1;
        lo_lim = -hi_lim - 1;
        q = (acc + (longint'(1) <<< (TAP_FRAC - 1))) >>> TAP_FRAC;
        if (q > hi_lim)
            q = hi_lim;
        else if (q < lo_lim)
            q = lo_lim;
        return q[SAMPLE_WIDTH-1:0];
    endfunction

    // Direct-form sum over the taps in use; the last tap in use weighs the
    // newest sample.
    function automatic cpx_t fir_output();
        longint acc_re;
        longint acc_im;
        int     n;
        cpx_t   y;
        acc_re = 0;
        acc_im = 0;
        n = (taps_in_use > MAX_TAPS) ? MAX_TAPS : int'(taps_in_use);
        for (int j = 0; j < n; j++)
        begin
            acc_re += longint'(coef[j]) * longint'(hist_re[n - 1 - j]);
            acc_im += longint'(coef[j]) * longint'(hist_im[n - 1 - j]);
        end
        y.re = round_clamp(acc_re);
        y.im = cplx_mode ? round_clamp(acc_im) : '0;
        return y;
    endfunction

    // Track every accepted transaction on the three channels.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (k = 0; k < MAX_TAPS; k++)
            begin
                coef[k]    = '0;
                hist_re[k] = '0;
                hist_im[k] = '0;
            end
            taps_in_use = NUM_TAPS_W'(1);
            cplx_mode   = 1'b1;
            errors      = 0;
            filtered_q.delete();
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            // Compare a result transaction with the oldest prediction.
            if (out_valid && !out_stall)
            begin
                if (filtered_q.size() == 0)
                begin
                    $display("%0t: unexpected result transaction: expected none, got re %0d im %0d",
                             $time, out_re, out_im);
                    errors++;
                end
                else
                begin
                    want = filtered_q.pop_front();
                    if (out_re !== want.re)
                    begin
                        $display("%0t: out_re mismatch: expected %0d, got %0d",
                                 $time, $signed(want.re), out_re);
                        errors++;
                    end
                    if (out_im !== want.im)
                    begin
                        $display("%0t: out_im mismatch: expected %0d, got %0d",
                                 $time, $signed(want.im), out_im);
                        errors++;
                    end
                end
            end

            // Register writes; unknown indexes leave everything as it was.
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_NUM_TAPS)
                    taps_in_use = cfg_data;
                else if (cfg_index == REG_COMPLEX_MODE)
                    cplx_mode = cfg_data[0];
            end

            // A tap load updates the store; a sample shifts the line and
            // produces one prediction.
            if (in_valid && !in_stall)
            begin
                if (req_type == REQ_LOAD)
                    coef[tap_index] = tap_value;
                else
                begin
                    for (k = MAX_TAPS - 1; k > 0; k--)
                    begin
                        hist_re[k] = hist_re[k - 1];
                        hist_im[k] = hist_im[k - 1];
                    end
                    hist_re[0] = sample_re;
                    hist_im[0] = cplx_mode ? sample_im : '0;
                    filtered_q.push_back(fir_output());
                end
            end

            mismatches  <= errors;
            outstanding <= filtered_q.size();
        end
    end

endmodule

@@ test/fir_filter_real_taps_test.sv @@
// ============================================================================
// fir_filter_real_taps_test: stimulus and verdict for the real-tap FIR filter
// Loads taps and streams real and complex samples through the filter under
// several register settings and handshake idling patterns, including a long
// receiver hold-off. A separate checker predicts and compares every result.
// ============================================================================
module fir_filter_real_taps_test;
    import firrt_pkg::*;

    localparam int IDLE_LIMIT        = 4000;
    localparam int HOLD_CYCLES       = 700;
    localparam int SETTLE_CYCLES     = MAX_TAPS + 8;
    localparam int ITEMS_PER_SETTING = 105;

    // Register indexes that the block does not decode.
    localparam cfg_idx_t REG_SPARE_2 = cfg_idx_t'(2);
    localparam cfg_idx_t REG_SPARE_3 = cfg_idx_t'(3);

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           in_valid  = 1'b0;
    logic                           in_stall;
    logic                           req_type  = REQ_SAMPLE;
    logic [TAP_INDEX_W-1:0]         tap_index = '0;
    logic signed [TAP_W-1:0]        tap_value = '0;
    logic signed [SAMPLE_WIDTH-1:0] sample_re = '0;
    logic signed [SAMPLE_WIDTH-1:0] sample_im = '0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    logic signed [SAMPLE_WIDTH-1:0] out_re;
    logic signed [SAMPLE_WIDTH-1:0] out_im;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [CFG_IDX_W-1:0]           cfg_index = '0;
    logic [CFG_DATA_W-1:0]          cfg_data  = '0;

    int   mismatches;
    int   outstanding;
    int   send_idle_pct  = 7;
    int   recv_stall_pct = 52;
    logic hold_req       = 1'b0;
    logic hold_taken     = 1'b0;
    int   hold_left      = 0;
    int   quiet_cycles   = 0;
    int   taps_setting   = 1;

    fir_filter_real_taps uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .req_type  (req_type),
        .tap_index (tap_index),
        .tap_value (tap_value),
        .sample_re (sample_re),
        .sample_im (sample_im),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_re    (out_re),
        .out_im    (out_im),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    fir_filter_real_taps_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .req_type    (req_type),
        .tap_index   (tap_index),
        .tap_value   (tap_value),
        .sample_re   (sample_re),
        .sample_im   (sample_im),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_re      (out_re),
        .out_im      (out_im),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // Free-running clock.
    initial
    begin
        forever #4 clk = ~clk;
    end

    // Result receiver: random stalls, plus one long hold-off on request.
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_req && !hold_taken)
        begin
            hold_taken <= 1'b1;
            hold_left  <= HOLD_CYCLES;
            out_stall  <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99, 0) < recv_stall_pct);
    end

    // Watchdog: end the run if no transaction moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Mostly random values, with the extremes and small values mixed in.
    function automatic logic signed [15:0] pick_word();
        case ($urandom_range(7, 0))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2:       return 16'($signed($urandom_range(64, 0)) - 32);
            default: return 16'($urandom());
        endcase
    endfunction

    // Offer one request transaction and wait until it is accepted.
    task automatic offer(input logic kind, input logic [TAP_INDEX_W-1:0] idx,
                         input logic signed [TAP_W-1:0] coef_val,
                         input logic signed [SAMPLE_WIDTH-1:0] re,
                         input logic signed [SAMPLE_WIDTH-1:0] im);
        while ($urandom_range(99, 0) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        req_type  <= kind;
        tap_index <= idx;
        tap_value <= coef_val;
        sample_re <= re;
        sample_im <= im;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic load_tap(input int idx, input logic signed [TAP_W-1:0] coef_val);
        offer(REQ_LOAD, TAP_INDEX_W'(idx), coef_val, 16'($urandom()), 16'($urandom()));
    endtask

    task automatic push_sample(input logic signed [SAMPLE_WIDTH-1:0] re,
                               input logic signed [SAMPLE_WIDTH-1:0] im);
        offer(REQ_SAMPLE, TAP_INDEX_W'($urandom()), 16'($urandom()), re, im);
    endtask

    // Register write transaction; cfg_valid is then dropped before the task returns.
    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Stop offering, wait for every predicted result, then let the MAC drain.
    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_taps(input logic [CFG_DATA_W-1:0] value);
        write_reg(REG_NUM_TAPS, value);
        taps_setting = (value > MAX_TAPS) ? MAX_TAPS : int'(value);
    endtask

    // Register setting for one slice of the random part.
    task automatic configure(input int regime, input int setting);
        logic [CFG_DATA_W-1:0] mode_word;
        mode_word = CFG_DATA_W'($urandom());
        case (setting)
            0:
            begin
                set_taps(CFG_DATA_W'(MAX_TAPS));
                mode_word[0] = 1'b1;
            end
            1:
            begin
                set_taps(CFG_DATA_W'(1));
                mode_word[0] = 1'b0;
            end
            2:       set_taps(regime[0] ? 8'hFF : 8'h00);
            3:
            begin
                set_taps(CFG_DATA_W'($urandom_range(255, MAX_TAPS + 1)));
                write_reg(regime[0] ? REG_SPARE_3 : REG_SPARE_2, CFG_DATA_W'($urandom()));
            end
            default: set_taps(CFG_DATA_W'($urandom_range(MAX_TAPS, 1)));
        endcase
        write_reg(REG_COMPLEX_MODE, mode_word);
    endtask

    // Tap updates among a stream of samples, with the loads mostly aimed at
    // the taps in use.
    task automatic random_items(input int count);
        int roll;
        for (int i = 0; i < count; i++)
        begin
            roll = $urandom_range(99, 0);
            if (roll < 16 && taps_setting > 0)
                load_tap($urandom_range(taps_setting - 1, 0), pick_word());
            else if (roll < 20)
                load_tap($urandom_range(MAX_TAPS - 1, 0), pick_word());
            else
                push_sample(pick_word(), pick_word());
        end
    endtask

    // Stimulus: reset, directed cases, then random slices under three idling
    // patterns.
    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Untouched taps give zero; then one full-scale tap, a half tap for
        // rounding ties, and a negative full-scale tap for saturation.
        push_sample(16'sh7FFF, 16'sh8000);
        load_tap(0, 16'sh7FFF);
        push_sample(16'sh8000, 16'sh7FFF);
        load_tap(0, 16'sh4000);
        push_sample(16'sh0001, -16'sh0001);
        push_sample(-16'sh0003, 16'sh0003);
        load_tap(0, 16'sh8000);
        push_sample(16'sh8000, 16'sh7FFF);
        load_tap(MAX_TAPS - 1, 16'sh8000);
        load_tap(MAX_TAPS - 2, 16'sh7FFF);

        // Full length in real mode: the imaginary part must read zero.
        settle();
        set_taps(CFG_DATA_W'(MAX_TAPS));
        write_reg(REG_COMPLEX_MODE, 8'h00);
        push_sample(16'sh7FFF, 16'sh7FFF);
        push_sample(16'sh8000, 16'sh8000);
        push_sample(16'sh8000, 16'sh1234);

        // No taps in use gives an empty sum.
        settle();
        set_taps(8'h00);
        write_reg(REG_COMPLEX_MODE, 8'hFF);
        push_sample(16'sh7FFF, 16'sh8000);

        // Too many taps is taken as the full store; a write to an unknown
        // index changes nothing.
        settle();
        set_taps(8'hFF);
        write_reg(REG_SPARE_2, 8'hAA);
        push_sample(16'sh7FFF, 16'sh8000);
        push_sample(16'sh8000, 16'sh7FFF);

        // Two taps, complex.
        settle();
        set_taps(CFG_DATA_W'(2));
        write_reg(REG_SPARE_3, 8'h55);
        push_sample(16'sh7FFF, 16'sh7FFF);
        push_sample(16'sh8000, -16'sh0001);

        // Random slices.
        for (int regime = 0; regime < 3; regime++)
        begin
            case (regime)
                0:
                begin
                    send_idle_pct  = 7;
                    recv_stall_pct <= 52;
                end
                1:
                begin
                    send_idle_pct  = 52;
                    recv_stall_pct <= 7;
                end
                default:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct <= 0;
                end
            endcase
            for (int setting = 0; setting < 6; setting++)
            begin
                settle();
                configure(regime, setting);
                // Hold the receiver off while samples keep coming.
                if (regime == 0 && setting == 1)
                    hold_req <= 1'b1;
                random_items(ITEMS_PER_SETTING);
            end
        end

        settle();
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
